@@ sv/sample_batcher_with_timeout_flush_unit_defines.svh @@
// Assertion macros for the sample batcher with timeout flush.
`ifndef SAMPLE_BATCHER_WITH_TIMEOUT_FLUSH_UNIT_DEFINES_SVH
`define SAMPLE_BATCHER_WITH_TIMEOUT_FLUSH_UNIT_DEFINES_SVH

// Condition that holds at every clock edge out of reset.
`define SBTF_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sbtf: invariant violated");

// Trigger in one cycle implies the result in the next cycle.
`define SBTF_ASSERT_NEXT(label, trig, result) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (result)) \
        else $error("sbtf: sequence violated");

`endif

@@ sv/sbtf_pkg.sv @@
// Types, constants and codes shared by the sample batcher modules.
`default_nettype none

package sbtf_pkg;

    // Sizing
    localparam int MAX_BATCH = 64;
    localparam int TIME_BITS = 48;
    localparam int CNT_W     = $clog2(MAX_BATCH + 1);
    localparam int IDX_W     = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;

    // Port widths
    localparam int NOW_W      = 48;
    localparam int AXIS_W     = 16;
    localparam int S_TDATA_W  = 144;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 192;
    localparam int BASE_W     = 48;
    localparam int SEQ_W      = 32;
    localparam int DELTA_W    = 16;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    // Register fields and reset values
    localparam int LIMIT_W   = 7;
    localparam int TIMEOUT_W = 32;
    localparam logic [LIMIT_W-1:0]   RESET_LIMIT   = 7'd50;
    localparam logic [TIMEOUT_W-1:0] RESET_TIMEOUT = 32'd500000;
    localparam logic [DELTA_W-1:0]   SAT_DELTA     = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_STOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DRAIN
    } state_t;

    typedef enum logic {
        REG_BATCH_LIMIT   = 1'b0,
        REG_FLUSH_TIMEOUT = 1'b1
    } reg_idx_t;

    typedef logic [TIME_BITS-1:0] time_t;

    // One stored sample
    typedef struct packed {
        logic signed [AXIS_W-1:0] gyro_z;
        logic signed [AXIS_W-1:0] gyro_y;
        logic signed [AXIS_W-1:0] gyro_x;
        logic signed [AXIS_W-1:0] accel_z;
        logic signed [AXIS_W-1:0] accel_y;
        logic signed [AXIS_W-1:0] accel_x;
        logic [DELTA_W-1:0]       offset_us;
    } sample_t;

    // Per-cell controls
    typedef struct packed {
        logic write;
        logic shift;
    } cell_ctl_t;

    // Configuration register values
    typedef struct packed {
        logic [LIMIT_W-1:0]   batch_limit;
        logic [TIMEOUT_W-1:0] flush_timeout;
    } cfg_t;

endpackage

`default_nettype wire

@@ sv/sbtf_cell.sv @@
// One storage cell of the sample chain: loads a new sample or takes its neighbor's.
`default_nettype none

module sbtf_cell
    import sbtf_pkg::*;
(
    input  wire logic      clk,
    input  wire cell_ctl_t ctl,
    input  wire sample_t   wr_data,
    input  wire sample_t   nxt_data,
    output sample_t        data
);

    sample_t data_reg;
    sample_t data_next;

    // Write wins over shift; the two never coincide
    always_comb
    begin
        data_next = data_reg;
        if (ctl.write)
        begin
            data_next = wr_data;
        end
        else if (ctl.shift)
        begin
            data_next = nxt_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

@@ sv/sbtf_cfg.sv @@
// APB configuration registers: batch limit and flush timeout.
`default_nettype none

module sbtf_cfg
    import sbtf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output cfg_t                    cfg
);

    logic [LIMIT_W-1:0]   limit_reg;
    logic [LIMIT_W-1:0]   limit_next;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [TIMEOUT_W-1:0] timeout_next;
    reg_idx_t             reg_sel;
    logic                 wr_en;

    // Word select; a write takes effect in the access phase
    assign reg_sel = reg_idx_t'(paddr[2]);
    assign wr_en   = psel & penable & pwrite;

    // Write decode
    always_comb
    begin
        limit_next   = limit_reg;
        timeout_next = timeout_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_BATCH_LIMIT:   limit_next   = pwdata[LIMIT_W-1:0];
                REG_FLUSH_TIMEOUT: timeout_next = pwdata[TIMEOUT_W-1:0];
                default:           limit_next   = limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= RESET_LIMIT;
            timeout_reg <= RESET_TIMEOUT;
        end
        else
        begin
            limit_reg   <= limit_next;
            timeout_reg <= timeout_next;
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_sel)
            REG_BATCH_LIMIT:   prdata = PDATA_W'(limit_reg);
            REG_FLUSH_TIMEOUT: prdata = PDATA_W'(timeout_reg);
            default:           prdata = '0;
        endcase
    end

    assign cfg.batch_limit   = limit_reg;
    assign cfg.flush_timeout = timeout_reg;

endmodule

`default_nettype wire

@@ sv/sample_batcher_with_timeout_flush_unit.sv @@
// Top level of the sample batcher: control, batch state and the chain of sample cells.
//
//  channel   dir  handshake         payload
//  s_*       in   tvalid / tready   tuser: cmd; tdata: now_us, accel x/y/z, gyro x/y/z
//  m_*       out  tvalid / tready   tdata: base, sequence, delta, sample; tlast: batch_end
//  apb       in   psel / penable    batch_limit at 0x0, flush_timeout at 0x4
//
// Every item is accepted in ST_IDLE and then updates the batch state in ST_EXEC
// in the control logic. A flush of n samples then shifts the cell chain toward
// the output register, one sample per cycle while m_tready is high, and the
// next item is not accepted until it is done. rst_n clears control state at
// once; the cells hold no reset value and need no clearing pass.
`default_nettype none
`include "sample_batcher_with_timeout_flush_unit_defines.svh"

module sample_batcher_with_timeout_flush_unit
    import sbtf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Input items
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // now_us, accel_x, accel_y, accel_z,
                                                 // gyro_x, gyro_y, gyro_z
    input  wire logic [S_TUSER_W-1:0] s_tuser,  // cmd
    // Result items
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,  // base_time, first_sequence, offset_us,
                                                 // out_accel_x/y/z, out_gyro_x/y/z
    output logic                      m_tlast,  // batch_end
    // Configuration
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [PDATA_W-1:0]   pwdata,
    output logic      [PDATA_W-1:0]   prdata,
    output logic                      pready
);

    cfg_t cfg;

    // Control state
    state_t             state_reg,     state_next;
    logic [CNT_W-1:0]   fill_reg,      fill_next;
    logic [SEQ_W-1:0]   seq_reg,       seq_next;
    time_t              base_reg,      base_next;
    logic [SEQ_W-1:0]   first_seq_reg, first_seq_next;
    time_t              last_send_reg, last_send_next;
    logic [CNT_W-1:0]   rem_reg,       rem_next;
    logic               m_tvalid_reg,  m_tvalid_next;

    // Latched input item
    cmd_t    cmd_reg;
    time_t   now_reg;
    sample_t smp_in_reg;

    // Output register payload
    logic [BASE_W-1:0] out_base_reg;
    logic [SEQ_W-1:0]  out_seq_reg;
    sample_t           out_smp_reg;
    logic              out_last_reg;

    // Update decode
    logic [CNT_W-1:0] wr_idx_full;
    logic [CNT_W-1:0] fill_after;
    logic [CNT_W-1:0] eff_limit;
    logic [CNT_W-1:0] flush_count;
    time_t            base_diff;
    time_t            send_diff;
    logic             timeout_hit;
    logic             do_flush;
    logic             smp_write;
    sample_t          new_sample;

    // Strobes
    logic exec_active;
    logic cell_wr;
    logic load_out;
    logic drain_last;
    logic in_accept;

    // Cell chain
    sample_t   cell_q   [MAX_BATCH];
    cell_ctl_t cell_ctl [MAX_BATCH];

    // Configuration port
    sbtf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    // Effective batch limit, clamped to 1..MAX_BATCH
    always_comb
    begin
        if (cfg.batch_limit == '0)
        begin
            eff_limit = CNT_W'(1);
        end
        else if (32'(cfg.batch_limit) > MAX_BATCH)
        begin
            eff_limit = CNT_W'(MAX_BATCH);
        end
        else
        begin
            eff_limit = CNT_W'(cfg.batch_limit);
        end
    end

    // Update decode for the latched item
    always_comb
    begin
        wr_idx_full = (fill_reg >= CNT_W'(MAX_BATCH)) ? CNT_W'(MAX_BATCH - 1) : fill_reg;
        fill_after  = wr_idx_full + CNT_W'(1);
        base_diff   = now_reg - base_reg;
        send_diff   = now_reg - last_send_reg;
        timeout_hit = (send_diff >= TIME_BITS'(cfg.flush_timeout));

        new_sample = smp_in_reg;
        if (fill_reg == '0)
        begin
            new_sample.offset_us = '0;
        end
        else if (|base_diff[TIME_BITS-1:DELTA_W])
        begin
            new_sample.offset_us = SAT_DELTA;
        end
        else
        begin
            new_sample.offset_us = base_diff[DELTA_W-1:0];
        end

        smp_write   = 1'b0;
        do_flush    = 1'b0;
        flush_count = fill_reg;
        case (cmd_reg)
            CMD_SAMPLE:
            begin
                smp_write   = 1'b1;
                do_flush    = (fill_after >= eff_limit) || timeout_hit;
                flush_count = fill_after;
            end
            CMD_TICK:
            begin
                do_flush = (fill_reg != '0) && timeout_hit;
            end
            CMD_STOP:
            begin
                do_flush = (fill_reg != '0);
            end
            default:
            begin
                do_flush = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = do_flush ? ST_DRAIN : ST_IDLE;
            end
            ST_DRAIN:
            begin
                if (drain_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        s_tready    = 1'b0;
        exec_active = 1'b0;
        load_out    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_EXEC:
            begin
                exec_active = 1'b1;
            end
            ST_DRAIN:
            begin
                load_out = !m_tvalid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign in_accept  = s_tvalid && s_tready;
    assign cell_wr    = exec_active && smp_write;
    assign drain_last = load_out && (rem_reg == CNT_W'(1));

    // Batch state next values
    always_comb
    begin
        fill_next      = fill_reg;
        seq_next       = seq_reg;
        base_next      = base_reg;
        first_seq_next = first_seq_reg;
        last_send_next = last_send_reg;
        rem_next       = rem_reg;

        if (exec_active)
        begin
            case (cmd_reg)
                CMD_START:
                begin
                    fill_next      = '0;
                    seq_next       = '0;
                    last_send_next = now_reg;
                end
                CMD_SAMPLE:
                begin
                    fill_next = fill_after;
                    seq_next  = seq_reg + SEQ_W'(1);
                    if (fill_reg == '0)
                    begin
                        base_next      = now_reg;
                        first_seq_next = seq_reg;
                    end
                end
                default:
                begin
                    fill_next = fill_reg;
                end
            endcase
            if (do_flush)
            begin
                fill_next      = '0;
                last_send_next = now_reg;
                rem_next       = flush_count;
            end
        end

        if (load_out)
        begin
            rem_next = rem_reg - CNT_W'(1);
        end
    end

    // Output valid
    always_comb
    begin
        if (load_out)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            seq_reg       <= '0;
            base_reg      <= '0;
            first_seq_reg <= '0;
            last_send_reg <= '0;
            rem_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            seq_reg       <= seq_next;
            base_reg      <= base_next;
            first_seq_reg <= first_seq_next;
            last_send_reg <= last_send_next;
            rem_reg       <= rem_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Input item latch
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg            <= cmd_t'(s_tuser);
            now_reg            <= TIME_BITS'(s_tdata[NOW_W-1:0]);
            smp_in_reg.offset_us <= '0;
            smp_in_reg.accel_x <= s_tdata[63:48];
            smp_in_reg.accel_y <= s_tdata[79:64];
            smp_in_reg.accel_z <= s_tdata[95:80];
            smp_in_reg.gyro_x  <= s_tdata[111:96];
            smp_in_reg.gyro_y  <= s_tdata[127:112];
            smp_in_reg.gyro_z  <= s_tdata[143:128];
        end
    end

    // Output register, fed from the head cell
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_base_reg <= BASE_W'(base_reg);
            out_seq_reg  <= first_seq_reg;
            out_smp_reg  <= cell_q[0];
            out_last_reg <= (rem_reg == CNT_W'(1));
        end
    end

    // Cell chain: write at the fill index, shift toward cell 0 on each output load
    for (genvar k = 0; k < MAX_BATCH; k++)
    begin : g_cell
        sample_t nxt;

        assign cell_ctl[k] = '{write: cell_wr && (wr_idx_full[IDX_W-1:0] == IDX_W'(k)),
                               shift: load_out};

        if (k == MAX_BATCH - 1)
        begin : g_tail
            assign nxt = cell_q[k];
        end
        else
        begin : g_body
            assign nxt = cell_q[k+1];
        end

        sbtf_cell u_cell (
            .clk      (clk),
            .ctl      (cell_ctl[k]),
            .wr_data  (new_sample),
            .nxt_data (nxt),
            .data     (cell_q[k])
        );
    end

    // Result item packing
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_smp_reg.gyro_z, out_smp_reg.gyro_y, out_smp_reg.gyro_x,
                       out_smp_reg.accel_z, out_smp_reg.accel_y, out_smp_reg.accel_x,
                       out_smp_reg.offset_us, out_seq_reg, out_base_reg};

    // Checks
    `SBTF_ASSERT_ALWAYS(a_drain_has_work, (state_reg == ST_DRAIN) == (rem_reg != '0))
    `SBTF_ASSERT_ALWAYS(a_fill_below_max, fill_reg < CNT_W'(MAX_BATCH))
    `SBTF_ASSERT_NEXT(a_last_ends_drain, drain_last, state_reg == ST_IDLE && m_tvalid && m_tlast)

endmodule

`default_nettype wire

@@ test/batch_flush_checker.sv @@
// Checker for the sample batcher: predicts flushed batches and compares the output stream.
`timescale 1ns / 1ps

module batch_flush_checker
    import sbtf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tlast,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    input  logic [PDATA_W-1:0]   prdata,
    input  logic                 pready,
    output int                   mismatches,
    output int                   results_owed
);

    // Layout of m_tdata, lowest field last
    typedef struct packed {
        logic [AXIS_W-1:0]  gyro_z;
        logic [AXIS_W-1:0]  gyro_y;
        logic [AXIS_W-1:0]  gyro_x;
        logic [AXIS_W-1:0]  accel_z;
        logic [AXIS_W-1:0]  accel_y;
        logic [AXIS_W-1:0]  accel_x;
        logic [DELTA_W-1:0] offset_us;
        logic [SEQ_W-1:0]   first_sequence;
        time_t              base_time;
    } batch_word_t;

    typedef struct {
        batch_word_t word;
        logic        batch_end;
    } flushed_sample_t;

    // Register copies
    logic [LIMIT_W-1:0]   limit_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;

    // Batch state
    int                 fill;
    logic [SEQ_W-1:0]   seq_count;
    logic [SEQ_W-1:0]   first_seq;
    time_t              base_t;
    time_t              last_send;
    logic [DELTA_W-1:0] delta_mem [MAX_BATCH];
    logic [6*AXIS_W-1:0] motion_mem [MAX_BATCH];

    flushed_sample_t owed_q [$];

    initial
    begin
        mismatches   = 0;
        results_owed = 0;
    end

    task automatic check_field(string name, logic [63:0] want, logic [63:0] seen);
        if (seen !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
        end
    endtask

    // Emit every stored sample of the open batch
    task automatic emit_batch(time_t now);
        flushed_sample_t r;
        for (int k = 0; k < fill; k++)
        begin
            r.word.base_time      = base_t;
            r.word.first_sequence = first_seq;
            r.word.offset_us      = delta_mem[k];
            {r.word.gyro_z, r.word.gyro_y, r.word.gyro_x,
             r.word.accel_z, r.word.accel_y, r.word.accel_x} = motion_mem[k];
            r.batch_end = (k + 1 == fill);
            owed_q.push_back(r);
        end
        if (fill > 0)
        begin
            fill      = 0;
            last_send = now;
        end
    endtask

    task automatic check_timeout(time_t now);
        time_t elapsed;
        elapsed = now - last_send;
        if (fill > 0 && elapsed >= time_t'(timeout_reg))
            emit_batch(now);
    endtask

    // Batch state update for one accepted item
    task automatic record_item(cmd_t c, time_t now, logic [6*AXIS_W-1:0] motion);
        int    idx;
        int    lim;
        time_t gap;
        case (c)
            CMD_START:
            begin
                fill      = 0;
                seq_count = '0;
                last_send = now;
            end
            CMD_SAMPLE:
            begin
                idx = (fill >= MAX_BATCH) ? MAX_BATCH - 1 : fill;
                if (fill == 0)
                begin
                    base_t         = now;
                    first_seq      = seq_count;
                    delta_mem[idx] = '0;
                end
                else
                begin
                    gap = now - base_t;
                    delta_mem[idx] = (gap > time_t'(SAT_DELTA)) ? SAT_DELTA
                                                                : gap[DELTA_W-1:0];
                end
                motion_mem[idx] = motion;
                fill      = idx + 1;
                seq_count = seq_count + 1'b1;
                // zero acts as one, anything above the store depth as full depth
                lim = (limit_reg == 0) ? 1 : int'(limit_reg);
                if (lim > MAX_BATCH)
                    lim = MAX_BATCH;
                if (fill >= lim)
                    emit_batch(now);
                else
                    check_timeout(now);
            end
            CMD_TICK:
                check_timeout(now);
            default:
                emit_batch(now);
        endcase
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            limit_reg   = RESET_LIMIT;
            timeout_reg = RESET_TIMEOUT;
            fill        = 0;
            seq_count   = '0;
            first_seq   = '0;
            base_t      = '0;
            last_send   = '0;
        end
        else
        begin
            // Output side first: a result never belongs to the item accepted at this edge
            if (m_tvalid && m_tready)
            begin
                if (owed_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, got %0h last %b",
                             $time, m_tdata, m_tlast);
                end
                else
                begin
                    flushed_sample_t want;
                    batch_word_t     got;
                    want = owed_q.pop_front();
                    got  = m_tdata;
                    check_field("base_time", 64'(want.word.base_time), 64'(got.base_time));
                    check_field("first_sequence", 64'(want.word.first_sequence),
                                64'(got.first_sequence));
                    check_field("offset_us", 64'(want.word.offset_us), 64'(got.offset_us));
                    check_field("accel_x", 64'(want.word.accel_x), 64'(got.accel_x));
                    check_field("accel_y", 64'(want.word.accel_y), 64'(got.accel_y));
                    check_field("accel_z", 64'(want.word.accel_z), 64'(got.accel_z));
                    check_field("gyro_x", 64'(want.word.gyro_x), 64'(got.gyro_x));
                    check_field("gyro_y", 64'(want.word.gyro_y), 64'(got.gyro_y));
                    check_field("gyro_z", 64'(want.word.gyro_z), 64'(got.gyro_z));
                    check_field("batch_end", 64'(want.batch_end), 64'(m_tlast));
                end
            end

            // Register accesses
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr == {REG_BATCH_LIMIT, 2'b00})
                        limit_reg = pwdata[LIMIT_W-1:0];
                    else if (paddr == {REG_FLUSH_TIMEOUT, 2'b00})
                        timeout_reg = pwdata[TIMEOUT_W-1:0];
                end
                else if (paddr == {REG_BATCH_LIMIT, 2'b00})
                    check_field("batch_limit read", 64'(limit_reg), 64'(prdata));
                else if (paddr == {REG_FLUSH_TIMEOUT, 2'b00})
                    check_field("flush_timeout read", 64'(timeout_reg), 64'(prdata));
            end

            // Input side
            if (s_tvalid && s_tready)
                record_item(cmd_t'(s_tuser), s_tdata[NOW_W-1:0],
                            s_tdata[S_TDATA_W-1:NOW_W]);
        end
        results_owed = owed_q.size();
    end

endmodule

@@ test/testbench.sv @@
// Top of the sample batcher testbench: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 1ps

module testbench
    import sbtf_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 8;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;  // now_us, accel_x/y/z, gyro_x/y/z
    logic [S_TUSER_W-1:0] s_tuser;  // cmd
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;  // base_time, first_sequence, offset_us,
                                    // out_accel_x/y/z, out_gyro_x/y/z
    logic                 m_tlast;  // batch_end
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    int    mismatches;
    int    results_owed;
    int    cycles = 0;
    int    items_sent;
    int    send_gap_max;
    int    recv_gap_max;
    bit    stall_request;
    bit    stall_done;
    time_t clock_us;

    always #6 clk = ~clk;

    sample_batcher_with_timeout_flush_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    batch_flush_checker check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .mismatches   (mismatches),
        .results_owed (results_owed)
    );

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: random stall after each result, one long hold when requested
    initial
    begin : receiver
        int idle_left;
        idle_left  = 0;
        stall_done = 1'b0;
        m_tready   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (stall_request && !stall_done)
                begin
                    idle_left  = LONG_HOLD;
                    stall_done = 1'b1;
                end
                else
                    idle_left = $urandom_range(0, recv_gap_max);
            end
            else if (idle_left > 0)
                idle_left--;
            m_tready <= rst_n && (idle_left == 0);
        end
    end

    // Advance the time base and offer one item until it is taken
    task automatic offer_item(cmd_t c, time_t adv, logic [6*AXIS_W-1:0] motion);
        int gap;
        clock_us = clock_us + adv;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= {motion, clock_us};
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    function automatic logic [6*AXIS_W-1:0] random_motion();
        return {$urandom, $urandom, $urandom};
    endfunction

    function automatic time_t random_time();
        return time_t'({$urandom, $urandom});
    endfunction

    // Mostly small steps, some past the delta ceiling, a few arbitrary jumps
    function automatic time_t draw_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return time_t'($urandom_range(0, 3000));
        else if (r < 93)
            return time_t'($urandom_range(60000, 90000));
        else if (r < 98)
            return time_t'($urandom_range(0, 2000000));
        return random_time();
    endfunction

    // Stop offering, wait for every owed result, let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (results_owed != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_access(bit wr, reg_idx_t r, logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {r, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // One batch session: start, samples with some ticks, often a stop; sometimes noise
    task automatic run_burst();
        int len;
        if ($urandom_range(0, 9) == 0)
        begin
            offer_item(cmd_t'($urandom_range(0, 3)), random_time(), random_motion());
            return;
        end
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 24);
        offer_item(CMD_START, draw_step(), random_motion());
        for (int k = 0; k < len; k++)
            offer_item(($urandom_range(0, 9) < 2) ? CMD_TICK : CMD_SAMPLE, draw_step(),
                       random_motion());
        if ($urandom_range(0, 1) == 1)
            offer_item(CMD_STOP, draw_step(), random_motion());
    endtask

    task automatic run_phase(logic [LIMIT_W-1:0] lim, logic [TIMEOUT_W-1:0] tmo, int count,
                             int sgap, int rgap);
        int target;
        drain();
        apb_access(1'b1, REG_BATCH_LIMIT, PDATA_W'(lim));
        apb_access(1'b1, REG_FLUSH_TIMEOUT, tmo);
        apb_access(1'b0, REG_BATCH_LIMIT, '0);
        apb_access(1'b0, REG_FLUSH_TIMEOUT, '0);
        send_gap_max = sgap;
        recv_gap_max = rgap;
        target = items_sent + count;
        while (items_sent < target)
            run_burst();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = CMD_START;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        items_sent    = 0;
        send_gap_max  = 4;
        recv_gap_max  = 4;
        stall_request = 1'b0;
        clock_us      = 48'hFFFF_FFFF_FF00;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset configuration (limit 50, timeout 500000)
        // sample before any start: long since the reset send time, flushes alone
        offer_item(CMD_SAMPLE, 48'd0, {6{16'h8000}});
        offer_item(CMD_START, 48'd5, random_motion());
        offer_item(CMD_SAMPLE, 48'd10, {6{16'h7FFF}});
        // crosses the 48-bit wrap
        offer_item(CMD_SAMPLE, 48'd256, {6{16'hFFFF}});
        // delta saturates
        offer_item(CMD_SAMPLE, 48'd70000, '0);
        offer_item(CMD_TICK, 48'd1000, random_motion());
        // timeout reached by a tick
        offer_item(CMD_TICK, 48'd500000, random_motion());
        // stop on an empty batch
        offer_item(CMD_STOP, 48'd3, random_motion());
        offer_item(CMD_SAMPLE, 48'd7, 96'h0123_4567_89AB_CDEF_FEDC_BA98);
        offer_item(CMD_SAMPLE, 48'd9, random_motion());
        offer_item(CMD_STOP, 48'd2, random_motion());
        offer_item(CMD_TICK, random_time(), random_motion());
        // start in the middle of a batch drops it
        offer_item(CMD_START, 48'd4, random_motion());
        offer_item(CMD_SAMPLE, 48'd4, random_motion());
        offer_item(CMD_SAMPLE, 48'd4, random_motion());
        offer_item(CMD_START, 48'd4, random_motion());
        offer_item(CMD_SAMPLE, 48'd4, random_motion());
        offer_item(CMD_STOP, 48'd4, random_motion());
        // timeout just below, then exactly at the threshold
        offer_item(CMD_START, 48'd100, random_motion());
        offer_item(CMD_SAMPLE, 48'd499999, random_motion());
        offer_item(CMD_SAMPLE, 48'd1, random_motion());

        // Random phases over register extremes and mixed settings
        run_phase(7'd1, 32'd0, 40, 18, 18);
        run_phase(7'd0, 32'hFFFF_FFFF, 40, 0, 0);
        run_phase(7'd127, 32'hFFFF_FFFF, 90, 3, 0);
        stall_request = 1'b1;
        run_phase(7'd4, 32'd100000, 60, 0, 4);
        run_phase(7'd64, $urandom_range(500, 20000), 60, 18, 0);
        for (int k = 0; k < 4; k++)
            run_phase(LIMIT_W'($urandom_range(0, 127)),
                      (k == 0) ? $urandom : $urandom_range(0, 30000), 50,
                      $urandom_range(0, 1) * 18, $urandom_range(0, 1) * 18);

        drain();
        if (mismatches == 0 && results_owed == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/sbtf_pkg.sv
sv/sbtf_cell.sv
sv/sbtf_cfg.sv
sv/sample_batcher_with_timeout_flush_unit.sv
test/batch_flush_checker.sv
test/testbench.sv
